>>> hdl/mec_pkg.sv
// Package: types, constants and register codes for the escape-count block.
`timescale 1ns / 1ps
package mec_pkg;

    // Fixed-point layout
    localparam int FRAC_BITS = 28;
    localparam int CFG_W     = 32;      // widest configuration register
    localparam int CFG_IDX_W = 3;
    localparam int COORD_W   = 10;
    localparam int COUNT_W   = 16;
    localparam int C_W       = 43;      // exact c = start + index * step
    localparam int Z_W       = 44;      // z after one update, before the bound test
    localparam int MUL_W     = 31;      // |z| < 4.0 in Q4.28 fits 31 signed bits
    localparam int SQ_W      = 2 * MUL_W;

    localparam logic signed [Z_W-1:0] COMP_BOUND = Z_W'(64'sd1 <<< (FRAC_BITS + 2));
    localparam logic [SQ_W:0]         ESC_NORM   = (SQ_W+1)'(64'd1 << (2 * FRAC_BITS + 4));

    // Reset values of the configuration registers
    localparam logic signed [CFG_W-1:0] X_START_RST    = -32'sd158376919;
    localparam logic signed [CFG_W-1:0] Y_START_RST    = 32'sd126164664;
    localparam logic signed [CFG_W-1:0] X_STEP_RST     = 32'sd7864;
    localparam logic signed [CFG_W-1:0] Y_STEP_RST     = 32'sd7864;
    localparam logic [COUNT_W-1:0]      ITER_LIMIT_RST = 16'd216;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_START    = 3'd0,
        REG_Y_START    = 3'd1,
        REG_X_STEP     = 3'd2,
        REG_Y_STEP     = 3'd3,
        REG_ITER_LIMIT = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_col;
        logic [COORD_W-1:0] pixel_row;
    } pix_in_t;

    typedef struct packed {
        logic [COORD_W-1:0] out_col;
        logic [COORD_W-1:0] out_row;
        logic [COUNT_W-1:0] escape_count;
    } pix_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CINIT,
        ST_TEST,
        ST_UPDATE,
        ST_DONE
    } mec_state_t;

    typedef struct packed {
        logic load_in;   // latch position and index * step products
        logic init;      // form c, clear z and count
        logic square;    // register re^2, im^2, re*im
        logic step;      // z = z^2 + c, count + 1
        logic load_out;  // move position and count into the result register
    } ctrl_cmd_t;

    typedef struct packed {
        logic count_lt;  // count below the limit
        logic bound_ok;  // both components inside +/-4.0
        logic norm_ok;   // re^2 + im^2 below 16
    } dp_status_t;

endpackage

>>> hdl/mec_ctrl.sv
// Controller: sequences accept, c set-up, square/update iterations and result hand-off.
`timescale 1ns / 1ps
module mec_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pixel_valid,
    output logic               pixel_ready,
    output logic               result_valid,
    input  logic               result_ready,
    input  mec_pkg::dp_status_t status,
    output mec_pkg::ctrl_cmd_t  cmd
);
    import mec_pkg::*;

    mec_state_t state_reg;
    mec_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pixel_valid)
                begin
                    state_next = ST_CINIT;
                end
            end
            ST_CINIT:
            begin
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                state_next = (status.count_lt && status.bound_ok) ? ST_UPDATE : ST_DONE;
            end
            ST_UPDATE:
            begin
                state_next = status.norm_ok ? ST_TEST : ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        pixel_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pixel_ready  = 1'b1;
                cmd.load_in  = pixel_valid;
            end
            ST_CINIT:
            begin
                cmd.init = 1'b1;
            end
            ST_TEST:
            begin
                cmd.square = status.count_lt && status.bound_ok;
            end
            ST_UPDATE:
            begin
                cmd.step = status.norm_ok;
            end
            ST_DONE:
            begin
                cmd.load_out = !out_valid_reg || result_ready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // a new word may replace the one being taken in the same cycle
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

>>> hdl/mec_datapath.sv
// Datapath: configuration registers, c forming, z iteration and result register.
`timescale 1ns / 1ps
module mec_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [mec_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mec_pkg::CFG_W-1:0]          cfg_data,
    input  mec_pkg::pix_in_t                   pixel,
    input  mec_pkg::ctrl_cmd_t                 cmd,
    output mec_pkg::dp_status_t                status,
    output mec_pkg::pix_out_t                  result
);
    import mec_pkg::*;

    logic signed [CFG_W-1:0] x_start_reg;
    logic signed [CFG_W-1:0] y_start_reg;
    logic signed [CFG_W-1:0] x_step_reg;
    logic signed [CFG_W-1:0] y_step_reg;
    logic [COUNT_W-1:0]      iter_limit_reg;

    logic [COORD_W-1:0]      col_reg;
    logic [COORD_W-1:0]      row_reg;
    logic signed [C_W-1:0]   prod_x_reg;
    logic signed [C_W-1:0]   prod_y_reg;
    logic signed [C_W-1:0]   prod_x_next;
    logic signed [C_W-1:0]   prod_y_next;
    logic signed [COORD_W:0] col_s;
    logic signed [COORD_W:0] row_s;

    logic signed [C_W-1:0]   cr_reg;
    logic signed [C_W-1:0]   ci_reg;
    logic signed [Z_W-1:0]   re_reg;
    logic signed [Z_W-1:0]   im_reg;
    logic signed [Z_W-1:0]   re_next;
    logic signed [Z_W-1:0]   im_next;
    logic [COUNT_W-1:0]      count_reg;

    logic signed [MUL_W-1:0] re_s;
    logic signed [MUL_W-1:0] im_s;
    logic signed [SQ_W-1:0]  rr_reg;
    logic signed [SQ_W-1:0]  ii_reg;
    logic signed [SQ_W-1:0]  ri_reg;
    logic signed [SQ_W:0]    diff;
    logic [SQ_W:0]           norm_sum;

    pix_out_t                result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_start_reg    <= X_START_RST;
            y_start_reg    <= Y_START_RST;
            x_step_reg     <= X_STEP_RST;
            y_step_reg     <= Y_STEP_RST;
            iter_limit_reg <= ITER_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_X_START:    x_start_reg    <= cfg_data;
                REG_Y_START:    y_start_reg    <= cfg_data;
                REG_X_STEP:     x_step_reg     <= cfg_data;
                REG_Y_STEP:     y_step_reg     <= cfg_data;
                REG_ITER_LIMIT: iter_limit_reg <= cfg_data[COUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // index * step, exact in C_W bits
    assign col_s       = signed'({1'b0, pixel.pixel_col});
    assign row_s       = signed'({1'b0, pixel.pixel_row});
    assign prod_x_next = col_s * x_step_reg;
    assign prod_y_next = row_s * y_step_reg;

    // only entered while both components lie inside +/-4.0
    assign re_s = re_reg[MUL_W-1:0];
    assign im_s = im_reg[MUL_W-1:0];

    // floor shifts: arithmetic right shift; 2*re*im / 2^28 = re*im / 2^27
    assign diff    = (SQ_W+1)'(rr_reg) - (SQ_W+1)'(ii_reg);
    assign re_next = Z_W'(diff >>> FRAC_BITS) + Z_W'(cr_reg);
    assign im_next = Z_W'(ri_reg >>> (FRAC_BITS - 1)) + Z_W'(ci_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            col_reg    <= pixel.pixel_col;
            row_reg    <= pixel.pixel_row;
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
        end
        if (cmd.init)
        begin
            cr_reg    <= C_W'(x_start_reg) + prod_x_reg;
            ci_reg    <= C_W'(y_start_reg) + prod_y_reg;
            re_reg    <= '0;
            im_reg    <= '0;
            count_reg <= '0;
        end
        if (cmd.square)
        begin
            rr_reg <= re_s * re_s;
            ii_reg <= im_s * im_s;
            ri_reg <= re_s * im_s;
        end
        if (cmd.step)
        begin
            re_reg    <= re_next;
            im_reg    <= im_next;
            count_reg <= count_reg + 1'b1;
        end
        if (cmd.load_out)
        begin
            result_reg.out_col      <= col_reg;
            result_reg.out_row      <= row_reg;
            result_reg.escape_count <= count_reg;
        end
    end

    // squares are never negative
    assign norm_sum = {1'b0, rr_reg} + {1'b0, ii_reg};

    assign status.count_lt = count_reg < iter_limit_reg;
    assign status.bound_ok = (re_reg < COMP_BOUND) && (re_reg > -COMP_BOUND) &&
                             (im_reg < COMP_BOUND) && (im_reg > -COMP_BOUND);
    assign status.norm_ok  = norm_sum < ESC_NORM;

    assign result = result_reg;

endmodule

>>> hdl/mandelbrot_escape_count.sv
// Top level of the Mandelbrot escape-time counter.
//
//  channel   direction  handshake                    word
//  pixel     in         pixel_valid / pixel_ready    pixel_col, pixel_row
//  result    out        result_valid / result_ready  out_col, out_row, escape_count
//  cfg       in         cfg_we (no wait)             cfg_index, cfg_data
//
// One pixel at a time: accept, form c, then per iteration a square step and then an
// update step on three 31x31 multipliers; the next pixel is accepted once the result
// is loaded. The square/update loop over the iteration count sets how long a pixel takes.
// Reset is asynchronous, active low; configuration returns to its reset values.
// A finished word waits in the result register; the next pixel is accepted meanwhile,
// and a further result is held back only while that register is still full.
`timescale 1ns / 1ps
module mandelbrot_escape_count (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pixel_valid,
    output logic                          pixel_ready,
    input  mec_pkg::pix_in_t              pixel,
    output logic                          result_valid,
    input  logic                          result_ready,
    output mec_pkg::pix_out_t             result,
    input  logic                          cfg_we,
    input  logic [mec_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mec_pkg::CFG_W-1:0]     cfg_data
);
    import mec_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    mec_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    mec_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule

>>> hdl/mec_checker.sv
// Port checker for the escape-time counter, bound to the top level.
`timescale 1ns / 1ps
module mec_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          pixel_valid,
    input logic                          pixel_ready,
    input logic                          result_valid,
    input logic                          result_ready,
    input mec_pkg::pix_out_t             result
);
    import mec_pkg::*;

    // a word not taken stays as it is
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // no second pixel during c set-up and the first test
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready |=> !pixel_ready ##1 !pixel_ready)
        else $error("pixel accepted while still busy");

    // no result can appear during c set-up and the first test after an accept
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready && !result_valid |=> !result_valid ##1 !result_valid)
        else $error("result appeared too early");

    // loading the result register frees the controller at once
    a_ready_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> pixel_ready)
        else $error("not ready after result load");

endmodule

bind mandelbrot_escape_count mec_checker u_mec_checker (.*);
